### rtl/core/olba_pkg.sv
// ----------------------------------------------------------------------------
// olba_pkg
// Shared types and constants for the one-lane bridge light arbiter.
// ----------------------------------------------------------------------------
package olba_pkg;

    // Default width of every car count
    localparam int COUNT_BITS_DEF = 8;

    // Width and reset value of the max_cross register
    localparam int          MAX_CROSS_W   = 8;
    localparam logic [7:0]  MAX_CROSS_RST = 8'd5;

    // Item kinds
    localparam logic FUNC_SENSOR = 1'b0;
    localparam logic FUNC_EXIT   = 1'b1;

    // Exit direction codes
    localparam logic EXIT_SOUTH = 1'b0;
    localparam logic EXIT_NORTH = 1'b1;

    // Direction of the last green
    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_NORTH = 2'd2
    } t_dir;

    // Light codes
    typedef enum logic [1:0] {
        LIGHT_RED   = 2'd0,
        LIGHT_SOUTH = 2'd1,
        LIGHT_NORTH = 2'd2
    } t_light;

    // One input word
    typedef struct packed {
        logic func;
        logic south_arrive;
        logic south_enter;
        logic north_arrive;
        logic north_enter;
        logic exit_dir;
    } t_item;

    // Decision taken for one item
    typedef struct packed {
        logic   emit;     // issue a light code
        t_light code;     // code to issue
        logic   change;   // clear let_through and set last_green
        t_dir   dir;      // new last_green on a change
    } t_decision;

endpackage

### rtl/core/olba_if.sv
// ----------------------------------------------------------------------------
// olba_in_if / olba_out_if
// Valid/ready channels carrying event words and light-code words.
// ----------------------------------------------------------------------------
interface olba_in_if;
    logic valid;
    logic ready;
    logic func;
    logic south_arrive;
    logic south_enter;
    logic north_arrive;
    logic north_enter;
    logic exit_dir;

    modport source (
        output valid, func, south_arrive, south_enter, north_arrive, north_enter, exit_dir,
        input  ready
    );
    modport sink (
        input  valid, func, south_arrive, south_enter, north_arrive, north_enter, exit_dir,
        output ready
    );
endinterface

interface olba_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] light_code;

    modport source (
        output valid, light_code,
        input  ready
    );
    modport sink (
        input  valid, light_code,
        output ready
    );
endinterface

### rtl/core/olba_decide.sv
// ----------------------------------------------------------------------------
// olba_decide
// Count update and light decision for one event word, purely combinational.
// ----------------------------------------------------------------------------
module olba_decide
    import olba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  t_item                   i_item,
    input  logic [MAX_CROSS_W-1:0]  i_max_cross,
    input  logic [COUNT_BITS-1:0]   i_south_waiting,
    input  logic [COUNT_BITS-1:0]   i_north_waiting,
    input  logic [COUNT_BITS-1:0]   i_south_on_bridge,
    input  logic [COUNT_BITS-1:0]   i_north_on_bridge,
    input  logic [COUNT_BITS-1:0]   i_let_through,
    input  t_dir                    i_last_green,
    input  t_light                  i_light_status,
    output logic [COUNT_BITS-1:0]   o_south_waiting,
    output logic [COUNT_BITS-1:0]   o_north_waiting,
    output logic [COUNT_BITS-1:0]   o_south_on_bridge,
    output logic [COUNT_BITS-1:0]   o_north_on_bridge,
    output logic [COUNT_BITS-1:0]   o_let_through,
    output t_decision               o_dec
);

    localparam int                    CMP_W   = (COUNT_BITS > MAX_CROSS_W) ?
                                                COUNT_BITS : MAX_CROSS_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
        inc_sat = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] dec_sat(input logic [COUNT_BITS-1:0] c);
        dec_sat = (c == '0) ? c : c - 1'b1;
    endfunction

    function automatic t_light light_of(input t_dir d);
        t_light l;
        unique case (d)
            DIR_SOUTH: l = LIGHT_SOUTH;
            DIR_NORTH: l = LIGHT_NORTH;
            default:   l = LIGHT_RED;
        endcase
        light_of = l;
    endfunction

    logic [COUNT_BITS-1:0] sw, nw, sob, nob, lt;
    logic                  idle;
    logic                  bridge_clear;
    logic                  over_limit;

    // Update counts: arrivals first, then entries; exits leave the bridge
    always_comb begin
        sw  = i_south_waiting;
        nw  = i_north_waiting;
        sob = i_south_on_bridge;
        nob = i_north_on_bridge;
        lt  = i_let_through;
        if (i_item.func == FUNC_SENSOR) begin
            if (i_item.south_arrive) sw = inc_sat(sw);
            if (i_item.north_arrive) nw = inc_sat(nw);
            if (i_item.south_enter) begin
                sw  = dec_sat(sw);
                lt  = inc_sat(lt);
                sob = inc_sat(sob);
            end
            if (i_item.north_enter) begin
                nw  = dec_sat(nw);
                lt  = inc_sat(lt);
                nob = inc_sat(nob);
            end
        end else if (i_item.exit_dir == EXIT_NORTH) begin
            nob = dec_sat(nob);
        end else begin
            sob = dec_sat(sob);
        end
    end

    assign o_south_waiting   = sw;
    assign o_north_waiting   = nw;
    assign o_south_on_bridge = sob;
    assign o_north_on_bridge = nob;
    assign o_let_through     = lt;

    assign bridge_clear = (sob == '0) && (nob == '0);
    assign idle         = bridge_clear && (sw == '0) && (nw == '0);
    assign over_limit   = CMP_W'(lt) > CMP_W'(i_max_cross);

    // Pick the light from the updated counts
    always_comb begin
        o_dec.emit   = 1'b0;
        o_dec.code   = LIGHT_RED;
        o_dec.change = 1'b0;
        o_dec.dir    = DIR_NONE;
        priority if (idle) begin
            o_dec.change = 1'b1;
            o_dec.dir    = DIR_NONE;
        end else if ((sw != '0) && (nw == '0)) begin
            if (nob != '0) begin
                o_dec.emit = 1'b1;
            end else if (i_last_green != DIR_SOUTH) begin
                o_dec.change = 1'b1;
                o_dec.dir    = DIR_SOUTH;
            end
        end else if ((nw != '0) && (sw == '0)) begin
            if (sob != '0) begin
                o_dec.emit = 1'b1;
            end else if (i_last_green != DIR_NORTH) begin
                o_dec.change = 1'b1;
                o_dec.dir    = DIR_NORTH;
            end
        end else if ((i_light_status == LIGHT_RED) && bridge_clear) begin
            if ((i_last_green == DIR_NORTH) || (i_last_green == DIR_NONE)) begin
                o_dec.change = 1'b1;
                o_dec.dir    = DIR_SOUTH;
            end else if (i_last_green == DIR_SOUTH) begin
                o_dec.change = 1'b1;
                o_dec.dir    = DIR_NORTH;
            end
        end else if (((i_light_status == LIGHT_NORTH) || (i_light_status == LIGHT_SOUTH))
                     && over_limit) begin
            o_dec.emit = 1'b1;
        end else begin
            // keep the lights as they are
            o_dec.emit = 1'b0;
        end
        // A change always issues the code of its direction
        if (o_dec.change) begin
            o_dec.emit = 1'b1;
            o_dec.code = light_of(o_dec.dir);
        end
    end

endmodule

### rtl/core/one_lane_bridge_light_arbiter.sv
// ----------------------------------------------------------------------------
// one_lane_bridge_light_arbiter
// Keeps queue and bridge counts for a one-lane bridge and issues light codes.
// ----------------------------------------------------------------------------
// Path: an accepted event word is held in the input register; its light code,
//   if any, moves into the output register when that register is free or draining.
// Throughput: one event word per cycle while the output is not stalled.
// Reset (synchronous, active low): all counts zero, last green none, lights
//   all red, max_cross 5, both stages empty; no words taken while in reset.
module one_lane_bridge_light_arbiter
    import olba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [MAX_CROSS_W-1:0] i_cfg_wdata,
    olba_in_if.sink                i_in,
    olba_out_if.source             o_out
);

    logic [MAX_CROSS_W-1:0] r_max_cross;
    logic                   r_in_valid;
    t_item                  r_item;
    logic                   r_out_valid;
    t_light                 r_out_code;

    logic [COUNT_BITS-1:0]  r_south_waiting, r_north_waiting;
    logic [COUNT_BITS-1:0]  r_south_on_bridge, r_north_on_bridge;
    logic [COUNT_BITS-1:0]  r_let_through;
    t_dir                   r_last_green;
    t_light                 r_light_status;

    logic [COUNT_BITS-1:0]  n_south_waiting, n_north_waiting;
    logic [COUNT_BITS-1:0]  n_south_on_bridge, n_north_on_bridge;
    logic [COUNT_BITS-1:0]  n_let_through;
    t_decision              n_dec;

    logic                   fire;
    logic                   in_accept;

    // Advance the held word when the output slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || fire);
    assign in_accept  = i_in.valid && i_in.ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cross <= MAX_CROSS_RST;
        end else if (i_cfg_we) begin
            r_max_cross <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.func         <= i_in.func;
            r_item.south_arrive <= i_in.south_arrive;
            r_item.south_enter  <= i_in.south_enter;
            r_item.north_arrive <= i_in.north_arrive;
            r_item.north_enter  <= i_in.north_enter;
            r_item.exit_dir     <= i_in.exit_dir;
        end
    end

    olba_decide #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .i_item            (r_item),
        .i_max_cross       (r_max_cross),
        .i_south_waiting   (r_south_waiting),
        .i_north_waiting   (r_north_waiting),
        .i_south_on_bridge (r_south_on_bridge),
        .i_north_on_bridge (r_north_on_bridge),
        .i_let_through     (r_let_through),
        .i_last_green      (r_last_green),
        .i_light_status    (r_light_status),
        .o_south_waiting   (n_south_waiting),
        .o_north_waiting   (n_north_waiting),
        .o_south_on_bridge (n_south_on_bridge),
        .o_north_on_bridge (n_north_on_bridge),
        .o_let_through     (n_let_through),
        .o_dec             (n_dec)
    );

    // Commit counts and light state for the word in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_south_waiting   <= '0;
            r_north_waiting   <= '0;
            r_south_on_bridge <= '0;
            r_north_on_bridge <= '0;
            r_let_through     <= '0;
            r_last_green      <= DIR_NONE;
            r_light_status    <= LIGHT_RED;
        end else if (fire) begin
            r_south_waiting   <= n_south_waiting;
            r_north_waiting   <= n_north_waiting;
            r_south_on_bridge <= n_south_on_bridge;
            r_north_on_bridge <= n_north_on_bridge;
            r_let_through     <= n_dec.change ? '0 : n_let_through;
            if (n_dec.change) begin
                r_last_green <= n_dec.dir;
            end
            if (n_dec.emit) begin
                r_light_status <= n_dec.code;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_dec.emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_dec.emit) begin
            r_out_code <= n_dec.code;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.light_code = r_out_code;

endmodule

### rtl/core/olba_checker.sv
// ----------------------------------------------------------------------------
// olba_checker
// Port-level checks for the bridge light arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module olba_checker
    import olba_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_light_code
);

    // A shown light code is always one of the three real codes
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_light_code == LIGHT_RED || i_light_code == LIGHT_SOUTH ||
                         i_light_code == LIGHT_NORTH))
        else $error("olba: illegal light code");

    // A fresh light code must follow an accepted event word
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("olba: light code without a source word");

    // Leaving reset, nothing is shown
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("olba: output valid straight after reset");

    // A stalled code holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_light_code)))
        else $error("olba: stalled light code changed");

endmodule

bind one_lane_bridge_light_arbiter olba_checker u_olba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_light_code (o_out.light_code)
);

### dv/olba_light_checker.sv
// ----------------------------------------------------------------------------
// olba_light_checker
// Watches the event and light-code channels of the bridge arbiter, keeps its
// own copy of the queue, bridge and crossing counts, predicts every light code
// and compares each accepted light-code word with the oldest prediction.
// ----------------------------------------------------------------------------
module olba_light_checker
    import olba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [MAX_CROSS_W-1:0] i_cfg_wdata,
    olba_in_if                     i_ev,
    olba_out_if                    i_light,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int CB         = COUNT_BITS_DEF;
    localparam int SHOW_LIMIT = 10;

    typedef logic [CB-1:0] t_count;

    // Predicted state of the arbiter
    t_count                 south_queue;
    t_count                 north_queue;
    t_count                 south_deck;
    t_count                 north_deck;
    t_count                 crossed;
    t_dir                   last_dir;
    t_light                 lights;
    logic [MAX_CROSS_W-1:0] cross_limit;

    // Light codes predicted but not yet seen on the output
    t_light light_expected[$];
    int     fails;
    int     checked;

    function automatic t_count count_up(input t_count c);
        return (c == {CB{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic t_count count_down(input t_count c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    // Change the lights: clear the crossing count and remember the direction
    task automatic switch_to(input t_dir dir, output bit has_code, output t_light code);
        case (dir)
            DIR_SOUTH: code = LIGHT_SOUTH;
            DIR_NORTH: code = LIGHT_NORTH;
            default:   code = LIGHT_RED;
        endcase
        crossed  = '0;
        last_dir = dir;
        lights   = code;
        has_code = 1'b1;
    endtask

    // Show red without counting it as a light change
    task automatic force_red(output bit has_code, output t_light code);
        code     = LIGHT_RED;
        lights   = LIGHT_RED;
        has_code = 1'b1;
    endtask

    // Advance the predicted state by one event word and decide on a light code
    task automatic take_word(input t_item w, output bit has_code, output t_light code);
        int unsigned total;
        int unsigned on_deck;
        has_code = 1'b0;
        code     = LIGHT_RED;
        if (w.func == FUNC_SENSOR) begin
            // arrivals first, then entries
            if (w.south_arrive) south_queue = count_up(south_queue);
            if (w.north_arrive) north_queue = count_up(north_queue);
            if (w.south_enter) begin
                south_queue = count_down(south_queue);
                crossed     = count_up(crossed);
                south_deck  = count_up(south_deck);
            end
            if (w.north_enter) begin
                north_queue = count_down(north_queue);
                crossed     = count_up(crossed);
                north_deck  = count_up(north_deck);
            end
        end else if (w.exit_dir == EXIT_NORTH) begin
            north_deck = count_down(north_deck);
        end else begin
            south_deck = count_down(south_deck);
        end

        on_deck = int'(south_deck) + int'(north_deck);
        total   = int'(south_queue) + int'(north_queue) + on_deck;

        if (total == 0) begin
            switch_to(DIR_NONE, has_code, code);
        end else if (south_queue != '0 && north_queue == '0) begin
            // lone south queue: green once the north cars are off
            if (north_deck == '0) begin
                if (last_dir != DIR_SOUTH) switch_to(DIR_SOUTH, has_code, code);
            end else begin
                force_red(has_code, code);
            end
        end else if (north_queue != '0 && south_queue == '0) begin
            if (south_deck == '0) begin
                if (last_dir != DIR_NORTH) switch_to(DIR_NORTH, has_code, code);
            end else begin
                force_red(has_code, code);
            end
        end else if (lights == LIGHT_RED && on_deck == 0) begin
            // both sides: alternate away from the last green
            if (last_dir == DIR_NORTH || last_dir == DIR_NONE) begin
                switch_to(DIR_SOUTH, has_code, code);
            end else if (last_dir == DIR_SOUTH) begin
                switch_to(DIR_NORTH, has_code, code);
            end
        end else if ((lights == LIGHT_NORTH || lights == LIGHT_SOUTH) && crossed > cross_limit) begin
            force_red(has_code, code);
        end
    endtask

    // Predict on each accepted event word, compare on each accepted light code
    always @(posedge i_clk) begin : watch
        bit     has_code;
        t_light code;
        t_light want;
        t_item  w;
        if (!i_rst_n) begin
            south_queue = '0;
            north_queue = '0;
            south_deck  = '0;
            north_deck  = '0;
            crossed     = '0;
            last_dir    = DIR_NONE;
            lights      = LIGHT_RED;
            cross_limit = MAX_CROSS_RST;
            light_expected.delete();
        end else begin
            if (i_cfg_we) cross_limit = i_cfg_wdata;

            if (i_light.valid && i_light.ready) begin
                if (light_expected.size() == 0) begin
                    if (fails < SHOW_LIMIT)
                        $display("unexpected light code word %0d at %0t",
                                 i_light.light_code, $realtime);
                    fails++;
                end else begin
                    want = light_expected.pop_front();
                    checked++;
                    if (i_light.light_code !== want) begin
                        if (fails < SHOW_LIMIT)
                            $display("light code mismatch at %0t: expected %0d, got %0d",
                                     $realtime, want, i_light.light_code);
                        fails++;
                    end
                end
            end

            if (i_ev.valid && i_ev.ready) begin
                w = {i_ev.func, i_ev.south_arrive, i_ev.south_enter,
                     i_ev.north_arrive, i_ev.north_enter, i_ev.exit_dir};
                take_word(w, has_code, code);
                if (has_code) light_expected.push_back(code);
            end
        end
        o_fail_count <= fails;
        o_pending    <= light_expected.size();
        o_checked    <= checked;
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the bridge arbiter with directed and random event words under
// several max_cross settings, random idling on both channels and one long
// output stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import olba_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_WAIT = 4;
    localparam int OPENING_N   = 24;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [MAX_CROSS_W-1:0] cfg_wdata;

    int          fail_count;
    int          pending;
    int          checked;
    int          words_sent;
    int          cycle_count = 0;
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    bit          hold_req;
    logic [7:0]  mid_limit;

    // Rough view of the traffic, used only to shape the stimulus
    int south_q;
    int north_q;
    int south_on;
    int north_on;

    // Opening words: {func, south_arrive, south_enter, north_arrive, north_enter, exit_dir}
    logic [5:0] opening_words [OPENING_N] = '{
        6'b1_0000_0, 6'b1_0000_1, 6'b0_0000_0, 6'b0_1000_0,
        6'b0_1000_0, 6'b0_0100_0, 6'b0_0010_0, 6'b0_1100_1,
        6'b0_1100_1, 6'b0_1100_1, 6'b0_1100_1, 6'b0_1100_0,
        6'b0_1100_0, 6'b1_1111_0, 6'b1_1111_0, 6'b1_1111_0,
        6'b1_0000_0, 6'b1_0000_0, 6'b0_0001_0, 6'b0_1111_1,
        6'b1_0000_1, 6'b1_0000_1, 6'b0_0101_0, 6'b1_0000_0
    };

    olba_in_if  ev_ch ();
    olba_out_if light_ch ();

    one_lane_bridge_light_arbiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (ev_ch),
        .o_out       (light_ch)
    );

    olba_light_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_ev         (ev_ch),
        .i_light      (light_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold while the sender keeps offering
    initial begin : light_sink
        bit hold_done;
        hold_done = 1'b0;
        light_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                light_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < out_idle_pct) begin
                light_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                light_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Follow the traffic as the stimulus sees it
    function automatic void track_view(input t_item w);
        if (w.func == FUNC_SENSOR) begin
            if (w.south_arrive) south_q++;
            if (w.north_arrive) north_q++;
            if (w.south_enter) begin
                if (south_q > 0) south_q--;
                south_on++;
            end
            if (w.north_enter) begin
                if (north_q > 0) north_q--;
                north_on++;
            end
        end else if (w.exit_dir == EXIT_NORTH) begin
            if (north_on > 0) north_on--;
        end else begin
            if (south_on > 0) south_on--;
        end
    endfunction

    // Offer one word, with an optional gap first, and hold it until taken
    task automatic send_word(input t_item w);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            ev_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        ev_ch.valid        <= 1'b1;
        ev_ch.func         <= w.func;
        ev_ch.south_arrive <= w.south_arrive;
        ev_ch.south_enter  <= w.south_enter;
        ev_ch.north_arrive <= w.north_arrive;
        ev_ch.north_enter  <= w.north_enter;
        ev_ch.exit_dir     <= w.exit_dir;
        @(posedge i_clk);
        while (!ev_ch.ready) @(posedge i_clk);
        words_sent++;
        track_view(w);
    endtask

    task automatic write_limit(input logic [MAX_CROSS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid and wait until every predicted light code has come out
    task automatic settle();
        ev_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Mostly plausible traffic, with a share of arbitrary words
    function automatic t_item traffic_word(input int unsigned noise_pct);
        t_item       w;
        logic [5:0]  bits;
        int unsigned r;
        r    = $urandom_range(0, 99);
        bits = 6'($urandom_range(0, 63));
        w    = bits;
        if (r < noise_pct) return w;
        if (south_on + north_on > 0 && r < noise_pct + 35) begin
            // a car leaves from a side that has cars on the bridge
            w.func = FUNC_EXIT;
            if (south_on == 0) w.exit_dir = EXIT_NORTH;
            else if (north_on == 0) w.exit_dir = EXIT_SOUTH;
            return w;
        end
        w.func         = FUNC_SENSOR;
        w.south_arrive = ($urandom_range(0, 2) == 0);
        w.north_arrive = ($urandom_range(0, 2) == 0);
        w.south_enter  = 1'b0;
        w.north_enter  = 1'b0;
        if (south_q > 0 && (north_q == 0 || $urandom_range(0, 1) == 1))
            w.south_enter = 1'($urandom_range(0, 1));
        else if (north_q > 0)
            w.north_enter = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic run_traffic(input int count, input int unsigned noise_pct);
        for (int k = 0; k < count; k++) send_word(traffic_word(noise_pct));
    endtask

    // Fill the south queue, or with entering set push south cars onto the bridge
    task automatic flood_south(input int count, input bit entering);
        t_item      w;
        logic [5:0] bits;
        for (int k = 0; k < count; k++) begin
            bits           = 6'($urandom_range(0, 63));
            w              = bits;
            w.func         = FUNC_SENSOR;
            w.south_arrive = 1'b1;
            if (entering) begin
                w.south_enter  = 1'b1;
                w.north_arrive = ($urandom_range(0, 7) == 0);
                w.north_enter  = ($urandom_range(0, 31) == 0);
            end else begin
                w.south_enter  = ($urandom_range(0, 15) == 0);
                w.north_arrive = ($urandom_range(0, 9) == 0);
                w.north_enter  = 1'b0;
            end
            send_word(w);
        end
    endtask

    initial begin : stimulus
        t_item w;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        ev_ch.valid        <= 1'b0;
        ev_ch.func         <= FUNC_SENSOR;
        ev_ch.south_arrive <= 1'b0;
        ev_ch.south_enter  <= 1'b0;
        ev_ch.north_arrive <= 1'b0;
        ev_ch.north_enter  <= 1'b0;
        ev_ch.exit_dir     <= EXIT_SOUTH;
        in_idle_pct  = 20;
        out_idle_pct = 20;
        hold_req     = 1'b0;
        words_sent   = 0;
        south_q      = 0;
        north_q      = 0;
        south_on     = 0;
        north_on     = 0;
        mid_limit    = 8'($urandom_range(2, 254));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset limit
        write_limit(MAX_CROSS_RST);
        for (int k = 0; k < OPENING_N; k++) begin
            w = opening_words[k];
            send_word(w);
        end

        // Zero limit: any crossing with both sides waiting forces red
        settle();
        write_limit(8'd0);
        in_idle_pct  = 25;
        out_idle_pct = 25;
        run_traffic(300, 10);

        // Limit of one, with a long output stall early in the phase
        settle();
        write_limit(8'd1);
        in_idle_pct  = 20;
        out_idle_pct = 30;
        hold_req     = 1'b1;
        run_traffic(300, 10);

        // Random limit, noisier traffic
        settle();
        write_limit(mid_limit);
        in_idle_pct  = 15;
        out_idle_pct = 15;
        run_traffic(250, 30);

        // Top limit: drive the south counts into saturation, the tail without idling
        settle();
        write_limit(8'd255);
        in_idle_pct  = 20;
        out_idle_pct = 20;
        flood_south(280, 1'b0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        flood_south(280, 1'b1);

        // Drain the remaining light codes
        ev_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d event words under max_cross 5, 0, 1, %0d and 255,",
                 words_sent, mid_limit);
        $display("with %0d light codes compared and %0d mismatches.", checked, fail_count);
        if (pending != 0)
            $display("%0d predicted light codes never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
